// File: design/assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`endif

`ifndef SYNTHESIS
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: design/gclp_pkg.sv
package gclp_pkg;

	localparam int CHAR_W          = 8;
	localparam int KEPT_W          = 8;
	localparam int LINE_LIMIT      = 128;
	localparam int FRACTION_DIGITS = 3;
	localparam int VALUE_W         = 32;
	localparam int CODE_W          = 16;
	localparam int AXES            = 5;
	localparam int AXIS_W          = 3;
	localparam int SCALE_W         = 10;
	localparam int USER_W          = 2;
	localparam int OUT_BITS        = CODE_W + AXES * VALUE_W + AXES;
	localparam int OUT_W           = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [VALUE_W-1:0] VALUE_CAP = VALUE_W'(1) << (VALUE_W - 1);
	localparam logic [CODE_W-1:0]  CODE_CAP  = CODE_W'(1) << (CODE_W - 1);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
	localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
	localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h58;
	localparam logic [CHAR_W-1:0] CH_Y     = 8'h59;
	localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

	localparam logic [AXIS_W-1:0] AX_X = 3'd0;
	localparam logic [AXIS_W-1:0] AX_Y = 3'd1;
	localparam logic [AXIS_W-1:0] AX_Z = 3'd2;
	localparam logic [AXIS_W-1:0] AX_A = 3'd3;
	localparam logic [AXIS_W-1:0] AX_F = 3'd4;

	typedef struct packed {
		logic              hit;
		logic [AXIS_W-1:0] idx;
	} axis_dec_t;

	function automatic axis_dec_t axis_decode(input logic [CHAR_W-1:0] ch);
		axis_dec_t r;
		r.hit = 1'b1;
		unique case (ch)
			CH_X: r.idx = AX_X;
			CH_Y: r.idx = AX_Y;
			CH_Z: r.idx = AX_Z;
			CH_A: r.idx = AX_A;
			CH_F: r.idx = AX_F;
			default: begin
				r.hit = 1'b0;
				r.idx = AX_X;
			end
		endcase
		return r;
	endfunction

	// magnitude times ten plus digit, clamped at the cap
	function automatic logic [VALUE_W-1:0] num_mul10(input logic [VALUE_W-1:0] mag,
			input logic [3:0] d);
		logic [VALUE_W:0] prod;
		prod = ({1'b0, mag} << 3) + ({1'b0, mag} << 1) + (VALUE_W+1)'(d);
		if (mag > VALUE_CAP / 10)
			return VALUE_CAP;
		else if (prod > {1'b0, VALUE_CAP})
			return VALUE_CAP;
		else
			return prod[VALUE_W-1:0];
	endfunction

	function automatic logic [CODE_W-1:0] code_mul10(input logic [CODE_W-1:0] mag,
			input logic [3:0] d);
		logic [CODE_W:0] prod;
		prod = ({1'b0, mag} << 3) + ({1'b0, mag} << 1) + (CODE_W+1)'(d);
		if (mag > CODE_CAP / 10)
			return CODE_CAP;
		else if (prod > {1'b0, CODE_CAP})
			return CODE_CAP;
		else
			return prod[CODE_W-1:0];
	endfunction

	// power of ten that fills the missing fraction digits
	function automatic logic [SCALE_W-1:0] frac_scale(input logic [1:0] fds);
		logic [SCALE_W-1:0] p;
		p = SCALE_W'(1);
		for (int i = 0; i < FRACTION_DIGITS; i++) begin
			if (i >= int'(fds))
				p = SCALE_W'((p << 3) + (p << 1));
		end
		return p;
	endfunction

endpackage

// File: design/gcode_line_word_parser.sv
// G-code line parser: one character per transfer in, one command record per line out.
// Input channel s_axis: tdata[7:0] is the character, tlast marks the line terminator;
// the character of a terminator transfer is ignored.
// Output channel m_axis: one transfer per terminator; tuser carries ok and the letter,
// tdata the code number, X/Y/Z/A/F values in signed thousandths and the mask of
// words seen.
// Throughput is one input transfer per cycle except while a terminator waits in the
// input register; characters keep flowing while a finished record waits on m_axis.
// A terminator is first taken into the input register; the parse logic then fills the
// record register from it, and m_axis presents the record from that register.
// A terminator waits in the input register only while the previous record is still
// unaccepted; the input stalls behind it until m_axis_tready frees the record register.
// Reset (arst_n low) clears the parse state, the stored word values and both
// valid flags; the next line starts fresh. Every terminator also returns the parse
// state to its reset value.
module gcode_line_word_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [gclp_pkg::CHAR_W-1:0]     s_axis_tdata,  // char_byte
	input  logic                            s_axis_tlast,  // line_end
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// code_num[16], x_val, y_val, z_val, a_val, f_val [32 each],
	// present_mask[5], zero pad
	output logic [gclp_pkg::OUT_W-1:0]      m_axis_tdata,
	output logic [gclp_pkg::USER_W-1:0]     m_axis_tuser   // ok, is_m
);
	import gclp_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_REJECT,
		PH_CODE_START,
		PH_CODE_DIG,
		PH_SCAN,
		PH_NUM_START,
		PH_NUM_INT,
		PH_NUM_FRAC
	} phase_t;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              advance;
	logic              fire;

	// parse state
	phase_t             phase_q, phase_n;
	logic [KEPT_W-1:0]  kept_q, kept_n;
	logic               is_m_q, is_m_n;
	logic [CODE_W-1:0]  code_accum_q, code_accum_n;
	logic [CODE_W-1:0]  code_val_q, code_val_n;
	logic               neg_q, neg_n;
	logic [AXIS_W-1:0]  axis_q, axis_n;
	logic [VALUE_W-1:0] num_accum_q, num_accum_n;
	logic [1:0]         fds_q, fds_n;
	logic               dseen_q, dseen_n;
	logic [VALUE_W-1:0] axis_val_q [AXES];
	logic [VALUE_W-1:0] axis_val_n [AXES];
	logic [AXES-1:0]    axis_present_q, axis_present_n;

	// result register
	logic              m_valid_q;
	logic [OUT_W-1:0]  m_data_q;
	logic [USER_W-1:0] m_user_q;
	logic [OUT_W-1:0]  result;
	logic [USER_W-1:0] result_user;
	logic              emit;

	// per-character decode
	logic [CHAR_W-1:0]  ch;
	logic               is_ws;
	logic               keep;
	logic               dig;
	logic               sign;
	logic [3:0]         dval;
	axis_dec_t          adec;
	logic [CODE_W-1:0]  code_mul;
	logic [VALUE_W-1:0] num_mul;
	logic [CODE_W-1:0]  code_commit;
	logic [VALUE_W-1:0] num_commit;
	logic [VALUE_W+SCALE_W-1:0] scaled;
	logic [VALUE_W-1:0] mag;

	assign advance       = !last_s1 || !m_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	always_comb begin
		ch = char_s1;
		if (char_s1 >= CH_LA && char_s1 <= CH_LZ)
			ch = char_s1 - CASE_GAP;
		is_ws = (char_s1 == CH_NUL) || (char_s1 == CH_SP) || (char_s1 == CH_TAB) ||
			(char_s1 == CH_LF) || (char_s1 == CH_VT) || (char_s1 == CH_FF) ||
			(char_s1 == CH_CR);
		keep = !is_ws && (kept_q < KEPT_W'(LINE_LIMIT));
		dig  = (ch >= CH_0) && (ch <= CH_9);
		sign = (ch == CH_PLUS) || (ch == CH_MINUS);
		dval = dig ? 4'(ch - CH_0) : 4'd0;
		adec = axis_decode(ch);
		code_mul = code_mul10(code_accum_q, dval);
		num_mul  = num_mul10(num_accum_q, dval);

		// pending code value
		code_commit = '0;
		if (dseen_q) begin
			if (neg_q)
				code_commit = CODE_W'(0) - code_accum_q;
			else if (code_accum_q > CODE_CAP - CODE_W'(1))
				code_commit = CODE_CAP - CODE_W'(1);
			else
				code_commit = code_accum_q;
		end

		// pending word value, scaled to full fraction digits
		scaled = num_accum_q * frac_scale(fds_q);
		mag = '0;
		if (dseen_q)
			mag = (scaled > (VALUE_W+SCALE_W)'(VALUE_CAP)) ? VALUE_CAP : scaled[VALUE_W-1:0];
		if (neg_q)
			num_commit = VALUE_W'(0) - mag;
		else if (mag > VALUE_CAP - 1)
			num_commit = VALUE_CAP - 1;
		else
			num_commit = mag;
	end

	always_comb begin
		logic do_scan;
		logic do_commit;
		logic ok;
		logic [CODE_W-1:0]  code_fin;
		logic [AXES-1:0]    mask_fin;
		logic [VALUE_W-1:0] val_fin [AXES];

		phase_n        = phase_q;
		kept_n         = kept_q;
		is_m_n         = is_m_q;
		code_accum_n   = code_accum_q;
		code_val_n     = code_val_q;
		neg_n          = neg_q;
		axis_n         = axis_q;
		num_accum_n    = num_accum_q;
		fds_n          = fds_q;
		dseen_n        = dseen_q;
		axis_val_n     = axis_val_q;
		axis_present_n = axis_present_q;
		do_scan        = 1'b0;
		do_commit      = 1'b0;
		emit           = 1'b0;
		result         = '0;
		result_user    = '0;
		ok             = 1'b0;
		code_fin       = code_val_q;
		mask_fin       = axis_present_q;
		val_fin        = axis_val_q;

		if (fire && last_s1) begin
			ok = (phase_q != PH_IDLE) && (phase_q != PH_REJECT);
			if (phase_q == PH_CODE_START || phase_q == PH_CODE_DIG)
				code_fin = code_commit;
			if (phase_q == PH_NUM_START || phase_q == PH_NUM_INT ||
					phase_q == PH_NUM_FRAC) begin
				val_fin[axis_q]  = num_commit;
				mask_fin[axis_q] = 1'b1;
			end
			emit = 1'b1;
			if (ok) begin
				result[OUT_BITS-1:0] = {mask_fin, val_fin[4], val_fin[3], val_fin[2],
					val_fin[1], val_fin[0], code_fin};
				result_user = {is_m_q, 1'b1};
			end
			phase_n        = PH_IDLE;
			kept_n         = '0;
			is_m_n         = 1'b0;
			code_accum_n   = '0;
			code_val_n     = '0;
			neg_n          = 1'b0;
			axis_n         = AX_X;
			num_accum_n    = '0;
			fds_n          = '0;
			dseen_n        = 1'b0;
			axis_present_n = '0;
			for (int i = 0; i < AXES; i++)
				axis_val_n[i] = '0;
		end else if (fire && keep) begin
			kept_n = kept_q + KEPT_W'(1);
			unique case (phase_q) inside
				PH_IDLE: begin
					if (ch == CH_G || ch == CH_M) begin
						is_m_n       = (ch == CH_M);
						neg_n        = 1'b0;
						num_accum_n  = '0;
						fds_n        = '0;
						dseen_n      = 1'b0;
						code_accum_n = '0;
						phase_n      = PH_CODE_START;
					end else begin
						phase_n = PH_REJECT;
					end
				end
				PH_REJECT: begin
				end
				PH_CODE_START, PH_CODE_DIG: begin
					if (phase_q == PH_CODE_START && sign) begin
						neg_n   = (ch == CH_MINUS);
						phase_n = PH_CODE_DIG;
					end else if (dig) begin
						code_accum_n = code_mul;
						dseen_n      = 1'b1;
						phase_n      = PH_CODE_DIG;
					end else begin
						code_val_n = code_commit;
						phase_n    = PH_SCAN;
						do_scan    = 1'b1;
					end
				end
				PH_SCAN: begin
					do_scan = 1'b1;
				end
				PH_NUM_START, PH_NUM_INT: begin
					if (phase_q == PH_NUM_START && sign) begin
						neg_n   = (ch == CH_MINUS);
						phase_n = PH_NUM_INT;
					end else if (dig) begin
						num_accum_n = num_mul;
						dseen_n     = 1'b1;
						phase_n     = PH_NUM_INT;
					end else if (ch == CH_DOT) begin
						phase_n = PH_NUM_FRAC;
					end else begin
						do_commit = 1'b1;
						phase_n   = PH_SCAN;
						do_scan   = 1'b1;
					end
				end
				PH_NUM_FRAC: begin
					if (dig) begin
						dseen_n = 1'b1;
						if (int'(fds_q) < FRACTION_DIGITS) begin
							num_accum_n = num_mul;
							fds_n       = fds_q + 2'd1;
						end
					end else begin
						do_commit = 1'b1;
						phase_n   = PH_SCAN;
						do_scan   = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (do_commit) begin
				axis_val_n[axis_q]     = num_commit;
				axis_present_n[axis_q] = 1'b1;
			end
			if (do_scan && adec.hit) begin
				axis_n      = adec.idx;
				neg_n       = 1'b0;
				num_accum_n = '0;
				fds_n       = '0;
				dseen_n     = 1'b0;
				phase_n     = PH_NUM_START;
			end
		end else if (fire) begin
			// dropped character: whitespace or past the line limit
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			kept_q         <= '0;
			is_m_q         <= 1'b0;
			code_accum_q   <= '0;
			code_val_q     <= '0;
			neg_q          <= 1'b0;
			axis_q         <= AX_X;
			num_accum_q    <= '0;
			fds_q          <= '0;
			dseen_q        <= 1'b0;
			axis_present_q <= '0;
			for (int i = 0; i < AXES; i++)
				axis_val_q[i] <= '0;
			m_valid_q      <= 1'b0;
			m_data_q       <= '0;
			m_user_q       <= '0;
		end else begin
			phase_q        <= phase_n;
			kept_q         <= kept_n;
			is_m_q         <= is_m_n;
			code_accum_q   <= code_accum_n;
			code_val_q     <= code_val_n;
			neg_q          <= neg_n;
			axis_q         <= axis_n;
			num_accum_q    <= num_accum_n;
			fds_q          <= fds_n;
			dseen_q        <= dseen_n;
			axis_present_q <= axis_present_n;
			axis_val_q     <= axis_val_n;
			if (emit) begin
				m_valid_q <= 1'b1;
				m_data_q  <= result;
				m_user_q  <= result_user;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEVER(a_kept_bound, kept_q > KEPT_W'(LINE_LIMIT), "kept count past line limit")
	`ASSERT_NEVER(a_accum_cap, num_accum_q > VALUE_CAP, "word magnitude above cap")
	`ASSERT_CLK(a_line_reset, emit |=> phase_q == PH_IDLE && kept_q == '0, "line not cleared")
	`ASSERT_CLK(a_mask_phase, axis_present_q != '0 |-> phase_q >= PH_SCAN, "word before code")
	`ASSERT_CLK(a_emit_cause, $rose(m_valid_q) |-> $past(fire && last_s1), "record without terminator")

endmodule
